// ===== rtl/core/dmx_pkg.sv =====
// Shared types and constants for the DMX512 frame transmitter.
package dmx_pkg;

   localparam logic [2:0] PH_IDLE  = 3'd0;
   localparam logic [2:0] PH_BREAK = 3'd1;
   localparam logic [2:0] PH_MAB   = 3'd2;
   localparam logic [2:0] PH_SLOTS = 3'd3;
   localparam logic [2:0] PH_HOLD  = 3'd4;
   localparam logic [2:0] PH_GAP   = 3'd5;

   localparam logic [2:0] REG_BIT_TIME   = 3'd0;
   localparam logic [2:0] REG_BREAK      = 3'd1;
   localparam logic [2:0] REG_MAB        = 3'd2;
   localparam logic [2:0] REG_HOLD       = 3'd3;
   localparam logic [2:0] REG_GAP        = 3'd4;
   localparam logic [2:0] REG_PERIOD     = 3'd5;
   localparam logic [2:0] REG_SLOT_COUNT = 3'd6;

   localparam int MAX_SLOTS   = 513;
   localparam int WHEEL_STEPS = 768;

   localparam int ADDR_W = 5;
   localparam int DATA_W = 32;

   typedef struct packed {
      logic [7:0]  bit_time;
      logic [15:0] break_len;
      logic [15:0] mab_len;
      logic [15:0] hold_len;
      logic [15:0] gap_len;
      logic [19:0] period;
      logic [9:0]  slot_count;
   } cfg_type;

   typedef struct packed {
      logic       tx_line;
      logic       driver_enable;
      logic       run_led;
      logic [2:0] frame_phase;
   } result_type;

endpackage

// ===== rtl/core/dmx_csr.sv =====
// Configuration register file with APB-style access.
module dmx_csr (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [dmx_pkg::ADDR_W-1:0] paddr,
   input  logic [dmx_pkg::DATA_W-1:0] pwdata,
   output logic [dmx_pkg::DATA_W-1:0] prdata,
   output logic                       pready,
   output dmx_pkg::cfg_type           cfg
);
   import dmx_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [2:0] reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = paddr[ADDR_W-1:2];
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_BIT_TIME:   cfg_in.bit_time   = pwdata[7:0];
            REG_BREAK:      cfg_in.break_len  = pwdata[15:0];
            REG_MAB:        cfg_in.mab_len    = pwdata[15:0];
            REG_HOLD:       cfg_in.hold_len   = pwdata[15:0];
            REG_GAP:        cfg_in.gap_len    = pwdata[15:0];
            REG_PERIOD:     cfg_in.period     = pwdata[19:0];
            REG_SLOT_COUNT: cfg_in.slot_count = pwdata[9:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bit_time   <= 8'd4;
         cfg_ff.break_len  <= 16'd88;
         cfg_ff.mab_len    <= 16'd8;
         cfg_ff.hold_len   <= 16'd44;
         cfg_ff.gap_len    <= 16'd250;
         cfg_ff.period     <= 20'd40000;
         cfg_ff.slot_count <= 10'd513;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_idx)
         REG_BIT_TIME:   prdata = {24'd0, cfg_ff.bit_time};
         REG_BREAK:      prdata = {16'd0, cfg_ff.break_len};
         REG_MAB:        prdata = {16'd0, cfg_ff.mab_len};
         REG_HOLD:       prdata = {16'd0, cfg_ff.hold_len};
         REG_GAP:        prdata = {16'd0, cfg_ff.gap_len};
         REG_PERIOD:     prdata = {12'd0, cfg_ff.period};
         REG_SLOT_COUNT: prdata = {22'd0, cfg_ff.slot_count};
         default:        prdata = '0;
      endcase
   end

endmodule

// ===== rtl/core/dmx_engine.sv =====
// Frame sequencer: period trigger, phase timing, slot serializer and colour wheel.
module dmx_engine (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  dmx_pkg::cfg_type    cfg,
   output dmx_pkg::result_type result
);
   import dmx_pkg::*;

   localparam logic [9:0]  WHEEL_LAST = 10'(WHEEL_STEPS - 1);
   localparam logic [10:0] SLOT_MAX   = 11'(MAX_SLOTS);

   logic [2:0]  phase_ff,  phase_in;
   logic [15:0] ptimer_ff, ptimer_in;
   logic [19:0] period_ff, period_in;
   logic        pending_ff, pending_in;
   logic [9:0]  wheel_ff, wheel_in;
   logic [9:0]  latched_ff, latched_in;
   logic [9:0]  slot_ff, slot_in;
   logic [3:0]  bitn_ff, bitn_in;
   logic [7:0]  bitt_ff, bitt_in;
   logic        led_ff, led_in;

   function automatic logic [2:0] skip_empty(input logic [2:0] p, input cfg_type c);
      logic [2:0] q;
      q = p;
      if (q == PH_BREAK && c.break_len == 16'd0) q = PH_MAB;
      if (q == PH_MAB && c.mab_len == 16'd0) q = PH_SLOTS;
      if (q == PH_HOLD && c.hold_len == 16'd0) q = PH_GAP;
      if (q == PH_GAP && c.gap_len == 16'd0) q = PH_IDLE;
      return q;
   endfunction

   function automatic logic [7:0] slot_value(input logic [9:0] p, input logic [9:0] slot);
      logic [7:0] r, g, b, v;
      r = 8'd0;
      g = 8'd0;
      b = 8'd0;
      if (p <= 10'd255) begin
         r = p[7:0];
         b = ~p[7:0];
      end else if (p <= 10'd511) begin
         r = ~p[7:0];
         g = p[7:0];
      end else if (p <= 10'd767) begin
         g = ~p[7:0];
         b = p[7:0];
      end
      case (slot)
         10'd1:   v = r;
         10'd2:   v = g;
         10'd3:   v = b;
         default: v = 8'd0;
      endcase
      return v;
   endfunction

   logic [19:0] per_len;
   logic [20:0] period_sum;
   logic        timed;
   logic [15:0] len;
   logic [2:0]  target;
   logic [16:0] tsum;
   logic [7:0]  bt_len;
   logic [8:0]  bsum;
   logic [10:0] ssum;
   logic [10:0] eff_slots;
   logic        enter_en;
   logic [2:0]  enter_p;
   logic [7:0]  cur_value;
   logic [2:0]  bit_idx;

   always_comb begin
      phase_in   = phase_ff;
      ptimer_in  = ptimer_ff;
      period_in  = period_ff;
      pending_in = pending_ff;
      wheel_in   = wheel_ff;
      latched_in = latched_ff;
      slot_in    = slot_ff;
      bitn_in    = bitn_ff;
      bitt_in    = bitt_ff;
      led_in     = led_ff;

      per_len    = (cfg.period == 20'd0) ? 20'd1 : cfg.period;
      period_sum = {1'b0, period_ff} + 21'd1;
      bt_len     = (cfg.bit_time == 8'd0) ? 8'd1 : cfg.bit_time;
      bsum       = {1'b0, bitt_ff} + 9'd1;
      ssum       = {1'b0, slot_ff} + 11'd1;
      tsum       = {1'b0, ptimer_ff} + 17'd1;
      if (cfg.slot_count == 10'd0) begin
         eff_slots = 11'd1;
      end else if ({1'b0, cfg.slot_count} > SLOT_MAX) begin
         eff_slots = SLOT_MAX;
      end else begin
         eff_slots = {1'b0, cfg.slot_count};
      end

      timed    = 1'b0;
      len      = 16'd0;
      target   = PH_IDLE;
      enter_en = 1'b0;
      enter_p  = PH_IDLE;

      if (step) begin
         if (period_sum >= {1'b0, per_len}) begin
            period_in  = 20'd0;
            pending_in = 1'b1;
         end else begin
            period_in = period_sum[19:0];
         end

         case (phase_ff)
            PH_IDLE: begin
               phase_in = PH_IDLE;
            end
            PH_BREAK: begin
               timed  = 1'b1;
               len    = cfg.break_len;
               target = PH_MAB;
            end
            PH_MAB: begin
               timed  = 1'b1;
               len    = cfg.mab_len;
               target = PH_SLOTS;
            end
            PH_HOLD: begin
               timed  = 1'b1;
               len    = cfg.hold_len;
               target = PH_GAP;
            end
            PH_GAP: begin
               timed  = 1'b1;
               len    = cfg.gap_len;
               target = PH_IDLE;
            end
            PH_SLOTS: begin
               if (bsum >= {1'b0, bt_len}) begin
                  bitt_in = 8'd0;
                  if (bitn_ff >= 4'd10) begin
                     bitn_in = 4'd0;
                     slot_in = ssum[9:0];
                     if (ssum >= eff_slots) begin
                        enter_en = 1'b1;
                        enter_p  = PH_HOLD;
                     end
                  end else begin
                     bitn_in = bitn_ff + 4'd1;
                  end
               end else begin
                  bitt_in = bsum[7:0];
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase

         if (timed) begin
            ptimer_in = tsum[15:0];
            if (tsum >= {1'b0, len}) begin
               enter_en = 1'b1;
               enter_p  = target;
            end
         end

         if (enter_en) begin
            phase_in  = skip_empty(enter_p, cfg);
            ptimer_in = 16'd0;
            if (phase_in == PH_SLOTS) begin
               slot_in = 10'd0;
               bitn_in = 4'd0;
               bitt_in = 8'd0;
            end
         end

         if (phase_in == PH_IDLE && pending_in) begin
            pending_in = 1'b0;
            latched_in = wheel_ff;
            wheel_in   = (wheel_ff == WHEEL_LAST) ? 10'd0 : wheel_ff + 10'd1;
            led_in     = ~led_ff;
            phase_in   = skip_empty(PH_BREAK, cfg);
            ptimer_in  = 16'd0;
            if (phase_in == PH_SLOTS) begin
               slot_in = 10'd0;
               bitn_in = 4'd0;
               bitt_in = 8'd0;
            end
         end
      end
   end

   always_comb begin
      cur_value = slot_value(latched_in, slot_in);
      bit_idx   = bitn_in[2:0] - 3'd1;
      if (phase_in == PH_BREAK) begin
         result.tx_line = 1'b0;
      end else if (phase_in == PH_SLOTS) begin
         if (bitn_in == 4'd0) begin
            result.tx_line = 1'b0;
         end else if (bitn_in <= 4'd8) begin
            result.tx_line = cur_value[bit_idx];
         end else begin
            result.tx_line = 1'b1;
         end
      end else begin
         result.tx_line = 1'b1;
      end
      result.driver_enable = (phase_in == PH_BREAK) || (phase_in == PH_MAB) ||
                             (phase_in == PH_SLOTS) || (phase_in == PH_HOLD);
      result.run_led       = led_in;
      result.frame_phase   = phase_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         ptimer_ff  <= 16'd0;
         period_ff  <= 20'd0;
         pending_ff <= 1'b0;
         wheel_ff   <= 10'd0;
         latched_ff <= 10'd0;
         slot_ff    <= 10'd0;
         bitn_ff    <= 4'd0;
         bitt_ff    <= 8'd0;
         led_ff     <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         ptimer_ff  <= ptimer_in;
         period_ff  <= period_in;
         pending_ff <= pending_in;
         wheel_ff   <= wheel_in;
         latched_ff <= latched_in;
         slot_ff    <= slot_in;
         bitn_ff    <= bitn_in;
         bitt_ff    <= bitt_in;
         led_ff     <= led_in;
      end
   end

   a_hold_without_tick: assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(phase_ff) && $stable(wheel_ff) && $stable(period_ff))
      else $error("state moved without a tick");

   a_led_marks_frame_start: assert property (@(posedge clock) disable iff (reset)
      !$stable(led_ff) |-> latched_ff == $past(wheel_ff))
      else $error("led toggled without latching the wheel");

   a_bit_number_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_SLOTS |-> bitn_ff <= 4'd10)
      else $error("bit number past the second stop bit");

endmodule

// ===== rtl/core/dmx512_frame_transmitter_core.sv =====
// Top level of the DMX512 frame transmitter: CSR block, sequencer and result register.
//
// Usage:
//   req channel: one beat per microsecond, req_tick = 1 advances the
//   transmitter by one microsecond, req_tick = 0 leaves it unchanged.
//   rsp channel: exactly one beat per req beat, carrying the line level,
//   driver enable, run LED and frame phase for the coming microsecond.
//   rsp_valid rises in the cycle after req acceptance. Throughput is one
//   beat per cycle while the receiver does not stall; the sequencer state and
//   the result register are updated in the same cycle the req beat is taken.
//   A single result register separates the channels: req_ready stays high
//   while the result register is empty or being drained, so a stalled
//   receiver holds the pending beat and blocks only further req beats.
//   Reset (synchronous) returns all timers, the wheel and the LED to zero,
//   the phase to idle, the result register to empty and the registers
//   to their defaults (4 us bit, 88 us break, 8 us mark, 44 us hold,
//   250 us gap, 40 ms period, 513 slots).
//   Registers sit at byte offsets 4*i on the APB-style port; write them
//   only while no beat is outstanding.
module dmx512_frame_transmitter_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_tick,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_tx_line,
   output logic                       rsp_driver_enable,
   output logic                       rsp_run_led,
   output logic [2:0]                 rsp_frame_phase,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [dmx_pkg::ADDR_W-1:0] paddr,
   input  logic [dmx_pkg::DATA_W-1:0] pwdata,
   output logic [dmx_pkg::DATA_W-1:0] prdata,
   output logic                       pready
);
   import dmx_pkg::*;

   cfg_type    cfg;
   result_type result;
   result_type rsp_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;
   logic       step;

   dmx_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign step      = accept && req_tick;

   dmx_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .cfg    (cfg),
      .result (result)
   );

   always_comb begin
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_tx_line       = rsp_ff.tx_line;
   assign rsp_driver_enable = rsp_ff.driver_enable;
   assign rsp_run_led       = rsp_ff.run_led;
   assign rsp_frame_phase   = rsp_ff.frame_phase;

   a_beat_lands: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted beat produced no result");

endmodule
